>>> hw/rtl/tsd_pkg.sv
`timescale 1ns / 1ps

package tsd_pkg;

  localparam logic [7:0]        FAMILY_COUNT_REMAIN = 8'h10;
  localparam logic signed [23:0] POWER_ON_VALUE     = 24'sd21760;
  localparam logic [3:0]        FRAME_DONE          = 4'd9;
  localparam logic [3:0]        LAST_CRC_BYTE       = 4'd7;
  localparam logic [3:0]        CHECK_BYTE          = 4'd8;
  localparam logic [3:0]        RES_MIN             = 4'd9;
  localparam logic [3:0]        RES_MAX             = 4'd12;
  localparam logic [3:0]        RES_RESET           = 4'd12;
  localparam logic [7:0]        CRC_POLY            = 8'h8C;
  localparam logic signed [23:0] HALF_DEGREE_BIAS   = 24'sd64;

  localparam int unsigned DIV_STEPS = 16;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_CRC_BAD  = 2'd1,
    STATUS_ZERO_CPD = 2'd2,
    STATUS_POWER_ON = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_DIV
  } state_e;

endpackage

>>> hw/rtl/temp_scratchpad_decoder.sv
`timescale 1ns / 1ps
// Bytes 0 to 7 are accepted and give no result. Byte 8 gives its result in the
// cycle after it is accepted, except for family 0x10 with a good checksum and a
// nonzero count-per-degree, where the result is loaded once the serial divider
// has produced all 16 quotient bits. Throughput: one byte per cycle while no
// stalled result is held; the input also stalls while the division runs.
// Reset is asynchronous, active low; it clears the byte count, the checksum, the
// divider's step count and the output valid flag, and sets resolution to 12.
module temp_scratchpad_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               frame_start_i,
  input  logic [7:0]         family_code_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic signed [23:0] temperature_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_resolution_bits_i
);
  import tsd_pkg::*;

  state_e state_q, state_d;

  logic [3:0] res_q;
  logic [3:0] pos_q, pos_d;
  logic [7:0] lo_q, hi_q, cr_q, cpd_q;

  logic              out_valid_q, out_valid_d;
  status_e           out_status_q, out_status_d;
  logic signed [23:0] out_temp_q, out_temp_d;

  logic        in_acc;
  logic [3:0]  pos_eff;
  logic        crc_en;
  logic [7:0]  crc;
  logic        div_start;
  logic        div_busy;
  logic [15:0] quotient;

  logic [15:0] raw;
  logic [8:0]  diff;
  logic [7:0]  mag;
  logic [3:0]  res_c;
  logic [1:0]  drop;
  logic [15:0] masked;
  logic signed [23:0] temp_res;
  logic signed [23:0] temp_cr;
  logic signed [23:0] q_signed;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign pos_eff = frame_start_i ? 4'd0 : pos_q;
  assign crc_en  = in_acc && (pos_eff <= LAST_CRC_BYTE);

  tsd_crc8 u_crc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (crc_en),
    .restart_i(frame_start_i),
    .byte_i   (data_byte_i),
    .crc_o    (crc)
  );

  assign raw  = {hi_q, lo_q};
  assign diff = {1'b0, cpd_q} - {1'b0, cr_q};
  assign mag  = diff[8] ? 8'(-diff) : diff[7:0];

  tsd_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i({mag, 8'h00}),
    .divisor_i (cpd_q),
    .busy_o    (div_busy),
    .quotient_o(quotient)
  );

  // masked-resolution path
  always_comb begin
    if (res_q < RES_MIN) begin
      res_c = RES_MIN;
    end else if (res_q > RES_MAX) begin
      res_c = RES_MAX;
    end else begin
      res_c = res_q;
    end
    drop     = 2'(RES_MAX - res_c);
    masked   = raw & (16'hFFFF << drop);
    temp_res = {{4{masked[15]}}, masked, 4'h0};
  end

  // count-remain path: floor(raw/2)*256 + signed quotient - 64
  assign q_signed = diff[8] ? -$signed({8'h00, quotient}) : $signed({8'h00, quotient});
  assign temp_cr  = $signed({raw[15], raw[15:1], 8'h00}) + q_signed
                    - HALF_DEGREE_BIAS;

  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_temp_d   = out_temp_q;
    div_start    = 1'b0;
    in_stall_o   = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = out_valid_q && out_stall_i;
        if (in_acc) begin
          if (pos_eff <= LAST_CRC_BYTE) begin
            pos_d = pos_eff + 4'd1;
          end else if (pos_eff == CHECK_BYTE) begin
            pos_d = FRAME_DONE;
            if (crc != data_byte_i) begin
              out_valid_d  = 1'b1;
              out_status_d = STATUS_CRC_BAD;
              out_temp_d   = '0;
            end else if (family_code_i == FAMILY_COUNT_REMAIN) begin
              if (cpd_q == 8'h00) begin
                out_valid_d  = 1'b1;
                out_status_d = STATUS_ZERO_CPD;
                out_temp_d   = '0;
              end else begin
                div_start = 1'b1;
                state_d   = S_DIV;
              end
            end else begin
              out_valid_d  = 1'b1;
              out_status_d = (temp_res == POWER_ON_VALUE) ? STATUS_POWER_ON : STATUS_OK;
              out_temp_d   = temp_res;
            end
          end
        end
      end
      S_DIV: begin
        // wait for the quotient, then load the result
        if (!div_busy) begin
          out_valid_d  = 1'b1;
          out_status_d = (temp_cr == POWER_ON_VALUE) ? STATUS_POWER_ON : STATUS_OK;
          out_temp_d   = temp_cr;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= 4'd0;
      out_valid_q <= 1'b0;
      res_q       <= RES_RESET;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        res_q <= cfg_resolution_bits_i;
      end
    end
  end

  // capture the scratch-pad bytes the formulas need, and register the result
  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_temp_q   <= out_temp_d;
    if (in_acc) begin
      if (pos_eff == 4'd0) lo_q  <= data_byte_i;
      if (pos_eff == 4'd1) hi_q  <= data_byte_i;
      if (pos_eff == 4'd6) cr_q  <= data_byte_i;
      if (pos_eff == 4'd7) cpd_q <= data_byte_i;
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign temperature_o = out_temp_q;

endmodule

>>> hw/rtl/tsd_crc8.sv
`timescale 1ns / 1ps

module tsd_crc8 (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       restart_i,
  input  logic [7:0] byte_i,
  output logic [7:0] crc_o
);
  import tsd_pkg::*;

  logic [7:0] crc_q, crc_d;

  // reflected CRC-8, one bit of the byte per step, LSB first
  always_comb begin
    logic [7:0] c;
    logic [7:0] b;
    logic       mix;
    c = restart_i ? 8'h00 : crc_q;
    b = byte_i;
    for (int i = 0; i < 8; i++) begin
      mix = c[0] ^ b[0];
      c   = {1'b0, c[7:1]};
      if (mix) begin
        c = c ^ CRC_POLY;
      end
      b = {1'b0, b[7:1]};
    end
    crc_d = en_i ? c : crc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= 8'h00;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

>>> hw/rtl/tsd_div.sv
`timescale 1ns / 1ps

module tsd_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] dividend_i,
  input  logic [7:0]  divisor_i,
  output logic        busy_o,
  output logic [15:0] quotient_o
);
  import tsd_pkg::*;

  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]           rem_q, rem_d;
  logic [15:0]          quo_q, quo_d;
  logic [7:0]           dvs_q, dvs_d;
  logic [8:0]           shifted;

  // restoring division: one quotient bit per cycle, MSB first
  always_comb begin
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    shifted = {rem_q, quo_q[15]};
    if (start_i) begin
      cnt_d = DIV_CNT_W'(DIV_STEPS);
      rem_d = 8'h00;
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = 8'(shifted - {1'b0, dvs_q});
        quo_d = {quo_q[14:0], 1'b1};
      end else begin
        rem_d = shifted[7:0];
        quo_d = {quo_q[14:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = quo_q;

endmodule

>>> hw/rtl/tsd_checker.sv
`timescale 1ns / 1ps

module tsd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [1:0]         status_o,
  input logic signed [23:0] temperature_o
);
  import tsd_pkg::*;

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(temperature_o))
    else $error("stalled result beat dropped or changed");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_CRC_BAD || status_o == STATUS_ZERO_CPD)
      |-> temperature_o == '0)
    else $error("error status with nonzero temperature");

  a_power_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_POWER_ON |-> temperature_o == POWER_ON_VALUE)
    else $error("power-on flag on other temperature");

  a_ok_not_power_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_OK |-> temperature_o != POWER_ON_VALUE)
    else $error("power-on value not flagged");

  // a pending stalled result blocks new bytes
  a_in_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input accepted while result stalled");

endmodule

bind temp_scratchpad_decoder tsd_checker u_tsd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .temperature_o(temperature_o)
);
